// ===== rtl/swm_pkg.sv =====
// swm_pkg: shared constants and types of the sliding window median block
// no dependencies; imported by the interfaces and all modules
`default_nettype none

package swm_pkg;

  localparam int unsigned WINDOW_MAX  = 64;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned IDX_W       = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W       = 7;

  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(64);

  // one slot of the sorted chain
  typedef struct packed {
    logic                          vld;
    logic [IDX_W-1:0]              age;
    logic signed [SAMPLE_BITS-1:0] val;
  } swm_slot_t;

  // what a cell shows its neighbors
  typedef struct packed {
    swm_slot_t slot;
    logic      lt;
  } swm_nbr_t;

endpackage

`default_nettype wire

// ===== rtl/swm_sample_if.sv =====
// swm_sample_if: valid/ready channel carrying one input sample per beat
// depends on swm_pkg
`default_nettype none

interface swm_sample_if import swm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/swm_result_if.sv =====
// swm_result_if: valid/ready channel carrying one median result per beat
// depends on swm_pkg
`default_nettype none

interface swm_result_if import swm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;
  logic [CNT_W-1:0]              held_count;

  modport source (output valid, output median, output held_count, input ready);
  modport sink   (input valid, input median, input held_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/swm_cfg_if.sv =====
// swm_cfg_if: valid/ready write channel for the window length register
// depends on swm_pkg
`default_nettype none

interface swm_cfg_if import swm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] win_size;

  modport source (output valid, output win_size, input ready);
  modport sink   (input valid, input win_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// swm_cell: one slot of the sorted sample chain with its age tag
// depends on swm_pkg; instantiated in a row by sliding_window_median
`default_nettype none

module swm_cell import swm_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          flush_i,
  input  wire logic                          step_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x_i,
  input  wire logic                          full_i,
  input  wire logic [IDX_W-1:0]              age_lim_i,
  input  wire swm_nbr_t                      lower_i,
  input  wire swm_nbr_t                      upper_i,
  input  wire logic                          rem_seen_i,
  output swm_nbr_t                           self_o,
  output logic                               rem_seen_o
);

  swm_slot_t slot_q, slot_d;
  swm_slot_t pick;
  logic      rem, lt, below_r, take_keep, take_shift;

  // eviction of the oldest sample and order against the new one
  assign rem = full_i && slot_q.vld && (slot_q.age == age_lim_i);
  assign lt  = slot_q.vld && !rem && ($signed(slot_q.val) < $signed(x_i));

  assign self_o.slot = slot_q;
  assign self_o.lt   = lt;
  assign rem_seen_o  = rem_seen_i | rem;

  // below_r: no evicted slot at or below this one (it lies above, or there is none)
  assign below_r    = !(rem_seen_i || rem);
  assign take_keep  = below_r ? lt : upper_i.lt;
  assign take_shift = rem_seen_i ? !lt : !lower_i.lt;

  // choose the slot that lands here after removal and insertion
  always_comb begin
    if (take_keep) begin
      pick = below_r ? slot_q : upper_i.slot;
    end else if (take_shift) begin
      pick = rem_seen_i ? slot_q : lower_i.slot;
    end else begin
      pick.vld = 1'b1;
      pick.age = '1;
      pick.val = x_i;
    end
    slot_d     = pick;
    slot_d.age = pick.age + IDX_W'(1);
  end

  // slot register; a flush only drops the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (flush_i) begin
      slot_q.vld <= 1'b0;
    end else if (step_i) begin
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swm_mid_mean.sv =====
// swm_mid_mean: middle value or truncated mean of the middle pair, output register
// depends on swm_pkg; used by sliding_window_median
`default_nettype none

module swm_mid_mean import swm_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic signed [SAMPLE_BITS-1:0] lo_i,
  input  wire logic signed [SAMPLE_BITS-1:0] hi_i,
  input  wire logic [CNT_W-1:0]              cnt_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]      median_o,
  output logic [CNT_W-1:0]                   held_count_o
);

  logic signed [SAMPLE_BITS:0]   sum, sum_adj;
  logic signed [SAMPLE_BITS-1:0] med_d;
  logic                          vld_q;

  // sum at one extra bit, round toward zero before halving
  always_comb begin
    sum     = $signed({lo_i[SAMPLE_BITS-1], lo_i}) + $signed({hi_i[SAMPLE_BITS-1], hi_i});
    sum_adj = (sum[SAMPLE_BITS] && sum[0]) ? sum + (SAMPLE_BITS+1)'(1) : sum;
    med_d   = cnt_i[0] ? hi_i : sum_adj[SAMPLE_BITS:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      median_o     <= med_d;
      held_count_o <= cnt_i;
    end
  end

  assign out_valid_o = vld_q;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
// sliding_window_median: running median over the last win_size samples
// result path: the sample beat updates the cell row, the pick step registers the middle pair
//   and the mean step loads the output register; a new sample is accepted only in idle; a result
//   not yet taken holds the following one in the mean step until the output register frees
// reset: window length 64 and an empty window; a window length write also empties it
// depends on swm_pkg, swm_*_if, swm_cell, swm_mid_mean
`default_nettype none

module sliding_window_median import swm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  swm_sample_if.sink  sample_in,
  swm_cfg_if.sink     cfg_in,
  swm_result_if.source result_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PICK = 2'd1;
  localparam logic [1:0] ST_MEAN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] wsize_q, fill_q, fill_d, win_eff;
  logic             full, step, flush, load;
  logic [IDX_W-1:0] age_lim, mid;

  swm_nbr_t cell_st [WINDOW_MAX];
  logic     rem_seen [WINDOW_MAX+1];
  swm_nbr_t lower_nb [WINDOW_MAX];
  swm_nbr_t upper_nb [WINDOW_MAX];

  logic signed [SAMPLE_BITS-1:0] lo_d, hi_d, lo_q, hi_q;

  assign cfg_in.ready    = 1'b1;
  assign flush           = cfg_in.valid;
  assign sample_in.ready = (state_q == ST_IDLE);
  assign step            = sample_in.valid && sample_in.ready;

  // effective window: zero acts as one, large values saturate
  always_comb begin
    if (wsize_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (wsize_q > CNT_W'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = wsize_q;
    end
  end

  assign full    = (fill_q >= win_eff);
  assign age_lim = IDX_W'(win_eff - CNT_W'(1));
  assign fill_d  = full ? win_eff : fill_q + CNT_W'(1);

  // config register and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WINDOW_RESET;
      fill_q  <= '0;
    end else if (flush) begin
      wsize_q <= cfg_in.win_size;
      fill_q  <= '0;
    end else if (step) begin
      fill_q  <= fill_d;
    end
  end

  // neighbor wiring of the cell row, with fixed ends
  assign rem_seen[0] = 1'b0;
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (i == 0) begin
        lower_nb[i]      = '0;
        lower_nb[i].lt   = 1'b1;
      end else begin
        lower_nb[i]      = cell_st[i-1];
      end
      if (i == WINDOW_MAX-1) begin
        upper_nb[i]      = '0;
      end else begin
        upper_nb[i]      = cell_st[i+1];
      end
    end
  end

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    swm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .flush_i    (flush),
      .step_i     (step),
      .x_i        (sample_in.sample),
      .full_i     (full),
      .age_lim_i  (age_lim),
      .lower_i    (lower_nb[g]),
      .upper_i    (upper_nb[g]),
      .rem_seen_i (rem_seen[g]),
      .self_o     (cell_st[g]),
      .rem_seen_o (rem_seen[g+1])
    );
  end

  // pick the middle pair from the chain
  assign mid = IDX_W'(fill_q >> 1);
  always_comb begin
    hi_d = '0;
    lo_d = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (IDX_W'(i) == mid) begin
        hi_d = hi_d | cell_st[i].slot.val;
      end
      if (IDX_W'(i) == IDX_W'(mid - IDX_W'(1))) begin
        lo_d = lo_d | cell_st[i].slot.val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PICK) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  // sequencer
  assign load = (state_q == ST_MEAN) && (!result_out.valid || result_out.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (step) state_d = ST_PICK;
      ST_PICK: state_d = ST_MEAN;
      ST_MEAN: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  swm_mid_mean u_mean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .lo_i         (lo_q),
    .hi_i         (hi_q),
    .cnt_i        (fill_q),
    .out_ready_i  (result_out.ready),
    .out_valid_o  (result_out.valid),
    .median_o     (result_out.median),
    .held_count_o (result_out.held_count)
  );

endmodule

`default_nettype wire

// ===== test/swm_median_checker.sv =====
// swm_median_checker: watches the sample, window length and result channels of
// sliding_window_median, predicts every median and compares it field by field
// depends on swm_pkg and the swm_sample_if, swm_cfg_if, swm_result_if interfaces
`default_nettype none

module swm_median_checker import swm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  swm_sample_if     sample_mon,
  swm_cfg_if        cfg_mon,
  swm_result_if     result_mon,
  output int        mismatches_o,
  output int        pending_o,
  output int        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] median;
    logic [CNT_W-1:0]              held_count;
  } median_beat_t;

  // expected medians in beat order
  median_beat_t median_q[$];

  // predictor state: arrival ring, ascending copy, window bookkeeping
  logic signed [SAMPLE_BITS-1:0] arrival_ring [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] sorted_vals [WINDOW_MAX];
  int unsigned win_len   = WINDOW_MAX;
  int unsigned head_slot = 0;
  int unsigned held      = 0;
  int          mismatches = 0;
  int          checked    = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // first sorted position holding a value not below x
  function automatic int unsigned first_not_below(input logic signed [SAMPLE_BITS-1:0] x);
    int unsigned p = 0;
    while (p < held && sorted_vals[p] < x) p++;
    return p;
  endfunction

  // evict the oldest sample once full, insert the new one, take the median
  function automatic median_beat_t next_median(input logic signed [SAMPLE_BITS-1:0] x);
    int unsigned  slot;
    int unsigned  p;
    int unsigned  m;
    int           pair_sum;
    median_beat_t r;
    if (held >= win_len) begin
      slot = head_slot;
      p = first_not_below(arrival_ring[slot]);
      for (int unsigned i = p; i + 1 < held; i++) sorted_vals[i] = sorted_vals[i + 1];
      held--;
      head_slot = (head_slot + 1) % win_len;
    end else begin
      slot = (head_slot + held) % win_len;
    end
    arrival_ring[slot] = x;
    p = first_not_below(x);
    for (int unsigned i = held; i > p; i--) sorted_vals[i] = sorted_vals[i - 1];
    sorted_vals[p] = x;
    held++;
    m = held / 2;
    if (held % 2 == 1) begin
      r.median = sorted_vals[m];
    end else begin
      // mean of the middle pair, wide sum, truncated toward zero
      pair_sum = int'(sorted_vals[m - 1]) + int'(sorted_vals[m]);
      r.median = SAMPLE_BITS'(pair_sum / 2);
    end
    r.held_count = CNT_W'(held);
    return r;
  endfunction

  // per-edge monitor: results first, then window length writes, then samples
  always @(posedge clk_i or negedge rst_ni) begin
    median_beat_t want;
    if (!rst_ni) begin
      win_len   = WINDOW_MAX;
      head_slot = 0;
      held      = 0;
      median_q.delete();
    end else begin
      // result beat against the oldest expected median
      if (result_mon.valid === 1'b1 && result_mon.ready === 1'b1) begin
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result median %0d held_count %0d",
                                    result_mon.median, result_mon.held_count));
        end else begin
          want = median_q.pop_front();
          checked++;
          if (result_mon.median !== want.median)
            report_mismatch($sformatf("median %0d, expected %0d (held %0d)",
                                      result_mon.median, want.median, want.held_count));
          if (result_mon.held_count !== want.held_count)
            report_mismatch($sformatf("held_count %0d, expected %0d",
                                      result_mon.held_count, want.held_count));
        end
      end
      // window length write empties the window; zero means one, above max saturates
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        if (cfg_mon.win_size == 0) win_len = 1;
        else if (cfg_mon.win_size > WINDOW_MAX) win_len = WINDOW_MAX;
        else win_len = cfg_mon.win_size;
        head_slot = 0;
        held      = 0;
      end
      // sample beat yields exactly one expected median
      if (sample_mon.valid === 1'b1 && sample_mon.ready === 1'b1)
        median_q.push_back(next_median(sample_mon.sample));
    end
    mismatches_o <= mismatches;
    pending_o    <= median_q.size();
    checked_o    <= checked;
  end

endmodule

`default_nettype wire

// ===== test/tb_sliding_window_median.sv =====
// tb_sliding_window_median: drives samples and window length writes into
// sliding_window_median under several idle patterns and gives the verdict
// depends on swm_pkg, the swm_*_if interfaces and swm_median_checker
`default_nettype none

module tb_sliding_window_median;
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned DRAIN_LIMIT  = 5000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned samples_sent   = 0;
  int unsigned size_writes    = 0;
  int          mismatches;
  int          pending;
  int          checked;

  swm_sample_if sample_ch();
  swm_cfg_if    cfg_ch();
  swm_result_if result_ch();

  sliding_window_median dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_in  (sample_ch),
    .cfg_in     (cfg_ch),
    .result_out (result_ch)
  );

  swm_median_checker median_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_ch),
    .cfg_mon      (cfg_ch),
    .result_mon   (result_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #1 clk_i = ~clk_i;

  // hard stop
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side back pressure
  initial result_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idle(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 80 : (mode == IDLE_BOTH) ? 22 : 0;
    recv_stall_pct <= (mode == IDLE_RECV) ? 80 : (mode == IDLE_BOTH) ? 22 : 0;
  endtask

  // one sample beat, with an optional random gap ahead of it
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid  <= 1'b0;
      sample_ch.sample <= SAMPLE_BITS'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk_i); while (!sample_ch.ready);
    samples_sent++;
  endtask

  task automatic write_window(input logic [CNT_W-1:0] size);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.win_size <= size;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    size_writes++;
  endtask

  // wait for every expected median, then let the pipeline settle
  task automatic drain();
    int unsigned waited = 0;
    sample_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // full range, tight cluster with many repeats, both extremes, cluster around 12000
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return SAMPLE_BITS'($urandom);
      4, 5, 6:    return SAMPLE_BITS'(int'($urandom_range(8)) - 4);
      7:          return SAMPLE_BITS'(int'($urandom_range(3)) - 32768);
      8:          return SAMPLE_BITS'(32767 - int'($urandom_range(3)));
      default:    return SAMPLE_BITS'(int'($urandom_range(400)) + 11800);
    endcase
  endfunction

  initial begin
    int               wide_corners [8]  = '{32767, 32766, -32768, -32767, -1, 0, 1, -21846};
    int               short_corners [12] = '{-32768, -32767, -1, 0, 5, 5, 5, 5,
                                             -3, 2, 32767, 32767};
    int               single_corners [3] = '{7, -7, 32767};
    logic [CNT_W-1:0] sizes [12] = '{127, 65, 2, 64, 1, 5, 16, 33, 0, 3, 9, 64};

    sample_ch.valid    = 1'b0;
    sample_ch.sample   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.win_size    = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window: extremes, middle-pair mean near overflow, alternating bits
    set_idle(IDLE_NONE);
    foreach (wide_corners[i]) send_sample(SAMPLE_BITS'(wide_corners[i]));
    drain();

    // window of four: eviction, negative mean truncation, equal samples
    write_window(CNT_W'(4));
    foreach (short_corners[i]) send_sample(SAMPLE_BITS'(short_corners[i]));
    drain();

    // zero size acts as a window of one
    write_window(CNT_W'(0));
    foreach (single_corners[i]) send_sample(SAMPLE_BITS'(single_corners[i]));
    drain();

    // random phases over several window sizes and idle patterns
    foreach (sizes[i]) begin
      set_idle(idle_mode_e'(i % 4));
      write_window(sizes[i]);
      repeat (PHASE_ITEMS) send_sample(random_sample());
      drain();
    end

    $display("covered %0d samples across %0d window length writes, %0d medians compared",
             samples_sent, size_writes, checked);
    if (pending != 0) $display("%0d expected medians never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
